// ===== rtl/bcu_pkg.sv =====
// Shared widths and controller/datapath interface types for the binomial coefficient unit.
package bcu_pkg;

   localparam int RESULT_WIDTH = 64;
   localparam int OPER_WIDTH   = 32;
   localparam int HALF_WIDTH   = OPER_WIDTH / 2;
   localparam int PART_WIDTH   = RESULT_WIDTH + HALF_WIDTH;
   localparam int PROD_WIDTH   = RESULT_WIDTH + OPER_WIDTH;
   localparam int CNT_WIDTH    = $clog2(RESULT_WIDTH);

   typedef struct packed {
      logic load;
      logic mul_lo;
      logic mul_hi;
      logic sum;
      logic div_step;
      logic advance;
      logic out_load;
   } bcu_cmd_type;

   typedef struct packed {
      logic loop_done;
      logic prod_ovf;
      logic div_last;
   } bcu_status_type;

endpackage

// ===== rtl/binomial_coefficient_unit.sv =====
// Top level of the binomial coefficient unit: controller and datapath.
// Computes C(n,k) by the multiplicative recurrence, one item at a time. Each
// iteration passes through the loop check, the two halves of the split
// multiplier, the sum and overflow check, the restoring divider over all
// RESULT_WIDTH quotient bits, and the loop advance. An item takes
// min(k, n-k) iterations, or fewer when the product overflows. A choice
// larger than the set, or an empty choice, runs no iterations. A result waits
// in an output register while the next item is worked on; on overflow the
// coefficient is all ones and overflowed is set.
module binomial_coefficient_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_set_size,
   input  logic [31:0] req_choose_count,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_coefficient,
   output logic        rsp_overflowed
);
   import bcu_pkg::*;

   bcu_cmd_type    cmd;
   bcu_status_type status;

   bcu_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   bcu_datapath u_datapath (
      .clock            (clock),
      .req_set_size     (req_set_size),
      .req_choose_count (req_choose_count),
      .cmd              (cmd),
      .status           (status),
      .rsp_coefficient  (rsp_coefficient),
      .rsp_overflowed   (rsp_overflowed)
   );

endmodule

// ===== rtl/bcu_datapath.sv =====
// Datapath: operand registers, split multiplier, overflow check and restoring divider.
module bcu_datapath (
   input  logic                     clock,
   input  logic [31:0]              req_set_size,
   input  logic [31:0]              req_choose_count,
   input  bcu_pkg::bcu_cmd_type     cmd,
   output bcu_pkg::bcu_status_type  status,
   output logic [63:0]              rsp_coefficient,
   output logic                     rsp_overflowed
);
   import bcu_pkg::*;

   logic [OPER_WIDTH-1:0]   k_ff, k_in;
   logic [OPER_WIDTH-1:0]   i_ff, i_in;
   logic [OPER_WIDTH-1:0]   m_ff, m_in;
   logic [RESULT_WIDTH-1:0] acc_ff, acc_in;
   logic                    ovf_ff, ovf_in;
   logic [PART_WIDTH-1:0]   pl_ff, pl_in;
   logic [PART_WIDTH-1:0]   ph_ff, ph_in;
   logic [RESULT_WIDTH-1:0] q_ff, q_in;
   logic [OPER_WIDTH-1:0]   rem_ff, rem_in;
   logic [CNT_WIDTH-1:0]    cnt_ff, cnt_in;
   logic [63:0]             coef_ff, coef_in;
   logic                    oflag_ff, oflag_in;

   logic [OPER_WIDTH-1:0]   n_minus_k;
   logic                    too_many;
   logic [OPER_WIDTH-1:0]   k_eff;
   logic [PROD_WIDTH-1:0]   prod;
   logic                    prod_ovf;
   logic [OPER_WIDTH:0]     trial;
   logic                    fits;

   assign n_minus_k = req_set_size - req_choose_count;
   assign too_many  = req_choose_count > req_set_size;
   assign k_eff = too_many ? '0 :
                  ((req_choose_count > n_minus_k) ? n_minus_k : req_choose_count);

   assign prod = PROD_WIDTH'(pl_ff) + {ph_ff, {HALF_WIDTH{1'b0}}};
   assign prod_ovf = |prod[PROD_WIDTH-1:RESULT_WIDTH];

   assign trial = {rem_ff, q_ff[RESULT_WIDTH-1]};
   assign fits  = trial >= {1'b0, i_ff};

   always_comb begin
      k_in     = k_ff;
      i_in     = i_ff;
      m_in     = m_ff;
      acc_in   = acc_ff;
      ovf_in   = ovf_ff;
      pl_in    = pl_ff;
      ph_in    = ph_ff;
      q_in     = q_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      coef_in  = coef_ff;
      oflag_in = oflag_ff;
      if (cmd.load) begin
         k_in   = k_eff;
         i_in   = OPER_WIDTH'(1);
         m_in   = req_set_size;
         acc_in = too_many ? '0 : RESULT_WIDTH'(1);
         ovf_in = 1'b0;
      end
      if (cmd.mul_lo) begin
         pl_in = PART_WIDTH'(acc_ff) * PART_WIDTH'(m_ff[HALF_WIDTH-1:0]);
      end
      if (cmd.mul_hi) begin
         ph_in = PART_WIDTH'(acc_ff) * PART_WIDTH'(m_ff[OPER_WIDTH-1:HALF_WIDTH]);
      end
      if (cmd.sum) begin
         if (prod_ovf) begin
            acc_in = '1;
            ovf_in = 1'b1;
         end else begin
            q_in   = prod[RESULT_WIDTH-1:0];
            rem_in = '0;
            cnt_in = '0;
         end
      end
      if (cmd.div_step) begin
         q_in   = {q_ff[RESULT_WIDTH-2:0], fits};
         rem_in = fits ? OPER_WIDTH'(trial - {1'b0, i_ff}) : trial[OPER_WIDTH-1:0];
         cnt_in = cnt_ff + CNT_WIDTH'(1);
      end
      if (cmd.advance) begin
         acc_in = q_ff;
         i_in   = i_ff + OPER_WIDTH'(1);
         m_in   = m_ff - OPER_WIDTH'(1);
      end
      if (cmd.out_load) begin
         coef_in  = 64'(acc_ff);
         oflag_in = ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      k_ff     <= k_in;
      i_ff     <= i_in;
      m_ff     <= m_in;
      acc_ff   <= acc_in;
      ovf_ff   <= ovf_in;
      pl_ff    <= pl_in;
      ph_ff    <= ph_in;
      q_ff     <= q_in;
      rem_ff   <= rem_in;
      cnt_ff   <= cnt_in;
      coef_ff  <= coef_in;
      oflag_ff <= oflag_in;
   end

   assign status.loop_done = i_ff > k_ff;
   assign status.prod_ovf  = prod_ovf;
   assign status.div_last  = cnt_ff == CNT_WIDTH'(RESULT_WIDTH - 1);

   assign rsp_coefficient = coef_ff;
   assign rsp_overflowed  = oflag_ff;

endmodule

// ===== rtl/bcu_controller.sv =====
// Controller: sequences the multiply and divide steps of each iteration and owns the handshakes.
module bcu_controller (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  bcu_pkg::bcu_status_type  status,
   output bcu_pkg::bcu_cmd_type     cmd
);
   import bcu_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_CHECK  = 3'd1;
   localparam logic [2:0] ST_MUL_LO = 3'd2;
   localparam logic [2:0] ST_MUL_HI = 3'd3;
   localparam logic [2:0] ST_SUM    = 3'd4;
   localparam logic [2:0] ST_DIV    = 3'd5;
   localparam logic [2:0] ST_NEXT   = 3'd6;
   localparam logic [2:0] ST_DONE   = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = status.loop_done ? ST_DONE : ST_MUL_LO;
         end
         ST_MUL_LO: begin
            cmd.mul_lo = 1'b1;
            state_in   = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            cmd.mul_hi = 1'b1;
            state_in   = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum  = 1'b1;
            state_in = status.prod_ovf ? ST_DONE : ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_NEXT;
            end
         end
         ST_NEXT: begin
            cmd.advance = 1'b1;
            state_in    = ST_CHECK;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== verif/tb.sv =====
// Testbench for binomial_coefficient_unit: directed and random set sizes and choice counts,
// scored against an in-bench prediction.
`timescale 1ns / 100ps

module tb;
   import bcu_pkg::*;

   localparam int CYCLE_LIMIT = 3_000_000;
   localparam int REPORT_LIMIT = 10;

   typedef struct {
      logic [63:0] coefficient;
      logic        overflowed;
   } binomial_type;

   class coefficient_board;
      binomial_type pending_coefs[$];
      int        mismatches = 0;
      int        requests = 0;
      int        results = 0;
      int        saturated = 0;
      int        zero_coefs = 0;

      function binomial_type predict(logic [31:0] set_size, logic [31:0] choose_count);
         binomial_type res;
         logic [63:0] n, k, m, acc, maxv;
         n = set_size;
         k = choose_count;
         maxv = {64{1'b1}} >> (64 - RESULT_WIDTH);
         acc = 64'd1;
         res.overflowed = 1'b0;
         if (k > n) begin
            res.coefficient = '0;
            return res;
         end
         if (k > n - k) k = n - k;
         for (logic [63:0] i = 1; i <= k; i++) begin
            m = n - i + 1;
            if (acc > maxv / m) begin
               acc = maxv;
               res.overflowed = 1'b1;
               break;
            end
            acc = (acc * m) / i;
         end
         res.coefficient = acc & maxv;
         return res;
      endfunction

      function void note_request(logic [31:0] set_size, logic [31:0] choose_count);
         binomial_type res;
         res = predict(set_size, choose_count);
         if (res.overflowed) saturated++;
         if (res.coefficient == 0) zero_coefs++;
         pending_coefs.push_back(res);
         requests++;
      endfunction

      function void report(string what);
         mismatches++;
         if (mismatches <= REPORT_LIMIT) $display("mismatch: %s", what);
      endfunction

      function void check_result(logic [63:0] coefficient, logic overflowed);
         binomial_type want;
         results++;
         if (pending_coefs.size() == 0) begin
            report($sformatf("result %0h/%0b with no item waiting", coefficient, overflowed));
            return;
         end
         want = pending_coefs.pop_front();
         if (coefficient !== want.coefficient)
            report($sformatf("coefficient expected %0h actual %0h",
                             want.coefficient, coefficient));
         if (overflowed !== want.overflowed)
            report($sformatf("overflowed expected %0b actual %0b",
                             want.overflowed, overflowed));
      endfunction

      function int waiting();
         return pending_coefs.size();
      endfunction

      function void close_out();
         if (pending_coefs.size() != 0)
            report($sformatf("%0d results never arrived", pending_coefs.size()));
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_set_size = '0;
   logic [31:0] req_choose_count = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_coefficient;
   logic        rsp_overflowed;

   coefficient_board book = new();
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   int  hold_left = 0;
   bit  hold_armed = 1'b0;
   int  cycles = 0;

   binomial_coefficient_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_set_size     (req_set_size),
      .req_choose_count (req_choose_count),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_coefficient  (rsp_coefficient),
      .rsp_overflowed   (rsp_overflowed)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // receiver: random stalls, plus one long hold when armed
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_armed) begin
         hold_armed = 1'b0;
         hold_left = 400;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         book.check_result(rsp_coefficient, rsp_overflowed);
   end

   task automatic send_item(input logic [31:0] n, input logic [31:0] k);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_set_size <= n;
      req_choose_count <= k;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      book.note_request(n, k);
      @(negedge clock);
   endtask

   task automatic send_random(input int count);
      logic [31:0] n, k;
      repeat (count) begin
         case ($urandom_range(9))
            0, 1, 2, 3: begin
               n = $urandom_range(70);
               k = $urandom_range(n + 3);
            end
            4: begin
               n = $urandom_range(140, 60);
               k = $urandom_range(n);
            end
            5: begin
               n = $urandom;
               k = $urandom_range(3);
            end
            6: begin
               n = $urandom_range(32'hffff_ffff, 3);
               k = n - $urandom_range(3);
            end
            7: begin
               n = $urandom_range(32'h8000_0000);
               k = $urandom_range(32'hffff_ffff, n + 1);
            end
            default: begin
               n = $urandom;
               k = $urandom;
            end
         endcase
         send_item(n, k);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (book.waiting() != 0) @(negedge clock);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_idle_pct = 20;
      recv_stall_pct = 51;
      send_item(32'd0, 32'd0);
      send_item(32'd0, 32'hffff_ffff);
      send_item(32'hffff_ffff, 32'd0);
      send_item(32'hffff_ffff, 32'hffff_ffff);
      send_item(32'hffff_ffff, 32'd1);
      send_item(32'hffff_ffff, 32'hffff_fffe);
      send_item(32'hffff_ffff, 32'd2);
      send_item(32'hffff_ffff, 32'd3);
      send_item(32'hffff_fffe, 32'hffff_ffff);
      send_item(32'd5, 32'd7);
      send_item(32'd1, 32'd1);
      send_item(32'd2, 32'd1);
      send_item(32'd10, 32'd3);
      send_item(32'd10, 32'd7);
      send_item(32'd52, 32'd26);
      send_item(32'd62, 32'd31);
      send_item(32'd64, 32'd32);
      send_item(32'd66, 32'd33);
      send_item(32'd67, 32'd33);
      send_item(32'd68, 32'd34);
      send_item(32'd1000, 32'd12);
      send_item(32'h0001_0000, 32'd4);
      send_random(35);
      wait_drained();

      send_idle_pct = 51;
      recv_stall_pct = 20;
      send_random(35);
      wait_drained();

      // hold the result side while quick items pile up at the input
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_armed = 1'b1;
      repeat (12) send_item($urandom_range(1000), $urandom_range(1100, 1001));
      send_random(26);
      wait_drained();

      repeat (20) @(negedge clock);
      book.close_out();
      $display("covered %0d items, %0d results, %0d saturated, %0d zero coefficients",
               book.requests, book.results, book.saturated, book.zero_coefs);
      $display("mismatches %0d, cycles %0d", book.mismatches, cycles);
      if (book.mismatches == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/bcu_pkg.sv
rtl/bcu_datapath.sv
rtl/bcu_controller.sv
rtl/binomial_coefficient_unit.sv
verif/tb.sv
